/* rtl/i2cms_pkg.sv */
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared types and constants for the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

    localparam int MAX_CMD_BYTES_DEF  = 16;
    localparam int MAX_DATA_BYTES_DEF = 64;

    localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
    localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

    typedef enum logic [2:0] {
        MODE_WRITE = 3'd0,
        MODE_WR_RD = 3'd1,
        MODE_READ  = 3'd2,
        MODE_LOAD  = 3'd3,
        MODE_EVENT = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SEND  = 3'd2,
        ACT_RECEN = 3'd3,
        ACT_ACK   = 3'd4,
        ACT_STOP  = 3'd5
    } action_t;

    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_ADDR_W = 9'b000000010,
        PH_WRITE  = 9'b000000100,
        PH_ADDR_R = 9'b000001000,
        PH_RECEN  = 9'b000010000,
        PH_STORE  = 9'b000100000,
        PH_REREC  = 9'b001000000,
        PH_STOP   = 9'b010000000,
        PH_DONE   = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] dev_addr;
        logic [4:0] command_count;
        logic [6:0] data_count;
        logic [7:0] load_value;
        logic [7:0] bus_rx_value;
        logic       nak_seen;
    } req_item_t;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] send_value;
        logic       ack_level;
        logic       got_valid;
        logic [7:0] got_value;
        logic [5:0] got_index;
        logic       finished;
        logic       succeeded;
        logic       refused;
    } rsp_item_t;

endpackage

/* rtl/i2cms_channels.sv */
// ----------------------------------------------------------------------------
// i2cms channels
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface i2cms_req_if
    import i2cms_pkg::*;
;
    logic      valid;
    logic      ready;
    req_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface i2cms_rsp_if
    import i2cms_pkg::*;
;
    logic      valid;
    logic      ready;
    rsp_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* rtl/i2c_master_transfer_sequencer.sv */
// response: an accepted item's response item is registered in the output register
// throughput: one item per cycle unless rsp stalls; the send buffer read is prefetched at the next byte position
// the buffer is a single-port-write, registered-read memory with write-to-read forwarding
// reset: control state returns to idle at once; buffer contents are undefined until loaded
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer
// Steps one I2C master write, write-then-read or read-only transfer per bus event.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
#(
    parameter int MAX_CMD_BYTES  = MAX_CMD_BYTES_DEF,
    parameter int MAX_DATA_BYTES = MAX_DATA_BYTES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    i2cms_req_if.sink    req,
    i2cms_rsp_if.source  rsp
);

    localparam int BUF_DEPTH = MAX_CMD_BYTES + MAX_DATA_BYTES;
    localparam int ADDR_W    = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
    localparam int CMD_W     = $clog2(MAX_CMD_BYTES + 1);
    localparam int DATA_W    = $clog2(MAX_DATA_BYTES + 1);

    phase_t              phase_reg, phase_next;
    logic                busy_reg, busy_next;
    logic [7:0]          target_reg, target_next;
    logic [CMD_W-1:0]    cmd_total_reg, cmd_total_next;
    logic [DATA_W-1:0]   tx_total_reg, tx_total_next;
    logic [DATA_W-1:0]   rx_total_reg, rx_total_next;
    logic [CNT_W-1:0]    byte_pos_reg, byte_pos_next;
    logic [CNT_W-1:0]    load_pos_reg, load_pos_next;

    logic                out_valid_reg, out_valid_next;
    rsp_item_t           out_item_reg, out_item_next;

    logic [7:0]          buf_mem [BUF_DEPTH];
    logic [7:0]          rd_data_reg;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                rd_ok;

    logic                accept;
    req_item_t           in_item;
    logic [CNT_W-1:0]    cmd_ext;
    logic [CNT_W-1:0]    send_end;
    logic [CNT_W-1:0]    pos_inc;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign in_item   = req.item;
    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    assign cmd_ext  = CNT_W'(cmd_total_reg);
    assign send_end = cmd_ext + CNT_W'(tx_total_reg);
    assign pos_inc  = byte_pos_reg + CNT_W'(1);
    assign wr_addr  = load_pos_reg[ADDR_W-1:0];
    assign rd_addr  = byte_pos_next[ADDR_W-1:0];
    assign rd_ok    = int'(byte_pos_next) < BUF_DEPTH;

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        target_next    = target_reg;
        cmd_total_next = cmd_total_reg;
        tx_total_next  = tx_total_reg;
        rx_total_next  = rx_total_reg;
        byte_pos_next  = byte_pos_reg;
        load_pos_next  = load_pos_reg;
        wr_en          = 1'b0;
        out_item_next  = '0;
        out_valid_next = out_valid_reg && !rsp.ready;

        if (accept)
        begin
            out_valid_next = 1'b1;
            unique case (in_item.mode) inside
                MODE_WRITE, MODE_WR_RD, MODE_READ:
                begin
                    if (busy_reg)
                    begin
                        out_item_next.refused = 1'b1;
                    end
                    else
                    begin
                        target_next   = in_item.dev_addr;
                        byte_pos_next = '0;
                        busy_next     = 1'b1;
                        out_item_next.bus_action = ACT_START;
                        if (in_item.mode == MODE_READ)
                        begin
                            cmd_total_next = '0;
                            phase_next     = PH_ADDR_R;
                        end
                        else if (int'(in_item.command_count) > MAX_CMD_BYTES)
                        begin
                            cmd_total_next = CMD_W'(MAX_CMD_BYTES);
                            phase_next     = PH_ADDR_W;
                        end
                        else
                        begin
                            cmd_total_next = CMD_W'(in_item.command_count);
                            phase_next     = PH_ADDR_W;
                        end
                        tx_total_next = '0;
                        rx_total_next = '0;
                        if (int'(in_item.data_count) > MAX_DATA_BYTES)
                        begin
                            if (in_item.mode == MODE_WRITE)
                                tx_total_next = DATA_W'(MAX_DATA_BYTES);
                            else
                                rx_total_next = DATA_W'(MAX_DATA_BYTES);
                        end
                        else
                        begin
                            if (in_item.mode == MODE_WRITE)
                                tx_total_next = DATA_W'(in_item.data_count);
                            else
                                rx_total_next = DATA_W'(in_item.data_count);
                        end
                    end
                end
                MODE_LOAD:
                begin
                    if (!busy_reg && int'(load_pos_reg) < BUF_DEPTH)
                    begin
                        wr_en         = 1'b1;
                        load_pos_next = load_pos_reg + CNT_W'(1);
                    end
                end
                MODE_EVENT:
                begin
                    unique case (phase_reg)
                        PH_ADDR_W:
                        begin
                            out_item_next.bus_action = ACT_SEND;
                            out_item_next.send_value = target_reg & ADDR_WR_MASK;
                            phase_next = PH_WRITE;
                        end
                        PH_WRITE:
                        begin
                            if (in_item.nak_seen)
                            begin
                                out_item_next.bus_action = ACT_STOP;
                                out_item_next.finished   = 1'b1;
                                phase_next    = PH_IDLE;
                                busy_next     = 1'b0;
                                load_pos_next = '0;
                            end
                            else if (byte_pos_reg < cmd_ext)
                            begin
                                out_item_next.bus_action = ACT_SEND;
                                out_item_next.send_value = rd_data_reg;
                                byte_pos_next = pos_inc;
                            end
                            else if (rx_total_reg != '0)
                            begin
                                out_item_next.bus_action = ACT_START;
                                byte_pos_next = '0;
                                phase_next    = PH_ADDR_R;
                            end
                            else if (byte_pos_reg < send_end)
                            begin
                                out_item_next.bus_action = ACT_SEND;
                                out_item_next.send_value = rd_data_reg;
                                byte_pos_next = pos_inc;
                            end
                            else
                            begin
                                out_item_next.bus_action = ACT_STOP;
                                phase_next = PH_DONE;
                            end
                        end
                        PH_ADDR_R:
                        begin
                            out_item_next.bus_action = ACT_SEND;
                            out_item_next.send_value = target_reg | ADDR_RD_BIT;
                            phase_next = PH_RECEN;
                        end
                        PH_RECEN:
                        begin
                            if (in_item.nak_seen)
                            begin
                                out_item_next.bus_action = ACT_STOP;
                                out_item_next.finished   = 1'b1;
                                phase_next    = PH_IDLE;
                                busy_next     = 1'b0;
                                load_pos_next = '0;
                            end
                            else if (rx_total_reg == '0)
                            begin
                                out_item_next.bus_action = ACT_STOP;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                out_item_next.bus_action = ACT_RECEN;
                                byte_pos_next = '0;
                                phase_next    = PH_STORE;
                            end
                        end
                        PH_STORE:
                        begin
                            out_item_next.got_valid  = 1'b1;
                            out_item_next.got_value  = in_item.bus_rx_value;
                            out_item_next.got_index  = 6'(byte_pos_reg);
                            out_item_next.bus_action = ACT_ACK;
                            byte_pos_next = pos_inc;
                            if (pos_inc >= CNT_W'(rx_total_reg))
                            begin
                                out_item_next.ack_level = 1'b1;
                                phase_next = PH_STOP;
                            end
                            else
                            begin
                                phase_next = PH_REREC;
                            end
                        end
                        PH_REREC:
                        begin
                            out_item_next.bus_action = ACT_RECEN;
                            phase_next = PH_STORE;
                        end
                        PH_STOP:
                        begin
                            out_item_next.bus_action = ACT_STOP;
                            phase_next = PH_DONE;
                        end
                        PH_DONE:
                        begin
                            out_item_next.finished  = 1'b1;
                            out_item_next.succeeded = 1'b1;
                            phase_next    = PH_IDLE;
                            busy_next     = 1'b0;
                            load_pos_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            busy_reg      <= 1'b0;
            target_reg    <= '0;
            cmd_total_reg <= '0;
            tx_total_reg  <= '0;
            rx_total_reg  <= '0;
            byte_pos_reg  <= '0;
            load_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            target_reg    <= target_next;
            cmd_total_reg <= cmd_total_next;
            tx_total_reg  <= tx_total_next;
            rx_total_reg  <= rx_total_next;
            byte_pos_reg  <= byte_pos_next;
            load_pos_reg  <= load_pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // send buffer: one write port, registered read of the next byte position
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            buf_mem[wr_addr] <= in_item.load_value;
        end
        if (wr_en && wr_addr == rd_addr)
        begin
            rd_data_reg <= in_item.load_value;
        end
        else if (rd_ok)
        begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

endmodule
